FILE: src/panel_bitplane_packet_builder_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bit-plane packet builder
// Shared forms for the concurrent checks of the block.
// ----------------------------------------------------------------------------
`ifndef PANEL_BITPLANE_PACKET_BUILDER_CORE_ASSERT_SVH
`define PANEL_BITPLANE_PACKET_BUILDER_CORE_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent.
`define PBPB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pbpb check failed");

// Two consequents must hold in turn straight after the antecedent, the first and then the second.
`define PBPB_ASSERT_NEXT2(label, clk, rst_n, ante, first, second) \
	label: assert property (@(posedge clk) disable iff (!rst_n) \
		(ante) |=> (first) ##1 (second)) \
		else $error("pbpb check failed");

`endif

FILE: src/pbpb_pkg.sv
// ----------------------------------------------------------------------------
// pbpb_pkg
// Types, codes and helper functions of the bit-plane packet builder.
// ----------------------------------------------------------------------------
`default_nettype none

package pbpb_pkg;

	typedef enum logic [1:0] {
		OP_PIXEL = 2'd0,
		OP_GAMMA = 2'd1,
		OP_READ  = 2'd2,
		OP_SHOW  = 2'd3
	} op_t;

	typedef struct packed {
		op_t        operation;
		logic [3:0] col;
		logic [3:0] row;
		logic [7:0] value;
		logic [7:0] gamma_index;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
	} out_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PIXEL,
		ST_READ,
		ST_SHOW1,
		ST_SHOW2
	} state_t;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 8;

	localparam logic [CFG_INDEX_W-1:0] REG_ROTATION      = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_GAMMA_ENABLE  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_MAGIC_FIRST   = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_MAGIC_SECOND  = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_COMMAND = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_SHOW_COMMAND  = 3'd5;

	localparam logic [1:0] ROT_NONE          = 2'd0;
	localparam logic [1:0] ROT_QUARTER       = 2'd1;
	localparam logic [1:0] ROT_HALF          = 2'd2;
	localparam logic [1:0] ROT_THREE_QUARTER = 2'd3;

	localparam logic [3:0] COORD_MAX = 4'd15;

	localparam int ENTRIES      = 32;
	localparam int ENTRY_W      = 5;
	localparam int GAMMA_DEPTH  = 256;
	localparam int GAMMA_ADDR_W = 8;

	localparam logic [7:0] CRC_POLY = 8'h31;

	localparam int MAX_RESULTS = 3;
	localparam int OFIFO_DEPTH = 4;
	localparam int OFIFO_PTR_W = 2;
	localparam int OFIFO_CNT_W = 3;
	localparam logic [OFIFO_CNT_W-1:0] OFIFO_ACCEPT_MAX =
		OFIFO_CNT_W'(OFIFO_DEPTH - MAX_RESULTS);

	function automatic logic [7:0] crc8_update(input logic [7:0] crc_in,
		input logic [7:0] data);
		logic [7:0] crc;
		logic [7:0] d;
		crc = crc_in;
		d = data;
		for (int i = 0; i < 8; i++) begin
			if (crc[7] ^ d[7]) begin
				crc = {crc[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				crc = {crc[6:0], 1'b0};
			end
			d = {d[6:0], 1'b0};
		end
		return crc;
	endfunction

endpackage

`default_nettype wire

FILE: src/panel_bitplane_packet_builder_core.sv
// ----------------------------------------------------------------------------
// panel_bitplane_packet_builder_core
// Builds the bit-plane frame packet and show trailer for one 16x16 panel.
// ----------------------------------------------------------------------------
// Items are taken one at a time. A gamma load and a header or CRC read are
// done on acceptance, a pixel and a plane byte read add a write-back (the
// plane memory is read on acceptance and the merged or cleared entry is
// written back the cycle after, with the gamma lookup issued alongside),
// and a show item holds the block while its three trailer words are pushed
// into the four-word output queue. An item is taken only while at most one
// word waits in that queue. The plane store needs no clearing pass: a valid
// bit per entry makes untouched entries read as zero straight after reset.
`default_nettype none

module panel_bitplane_packet_builder_core import pbpb_pkg::*; #(
	parameter int PLANES    = 8,
	parameter int FRAME_LEN = 256
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output      logic                   in_stall,
	input  wire in_word_t               in_word,
	output      logic                   out_valid,
	input  wire logic                   out_stall,
	output      out_word_t              out_word,
	input  wire logic                   cfg_write,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int PLANE_W = 8 * PLANES;
	localparam int POS_W   = $clog2(FRAME_LEN + 4);

	localparam logic [POS_W-1:0] POS_MAGIC_FIRST  = POS_W'(0);
	localparam logic [POS_W-1:0] POS_MAGIC_SECOND = POS_W'(1);
	localparam logic [POS_W-1:0] POS_COMMAND      = POS_W'(2);
	localparam logic [POS_W-1:0] POS_FIRST_PLANE  = POS_W'(3);
	localparam logic [POS_W-1:0] POS_CRC          = POS_W'(FRAME_LEN + 3);

	logic [1:0] rotation_q;
	logic       gamma_enable_q;
	logic [7:0] magic_first_q;
	logic [7:0] magic_second_q;
	logic [7:0] frame_command_q;
	logic [7:0] show_command_q;

	state_t             state_q;
	state_t             state_next;
	logic [POS_W-1:0]   pos_q;
	logic [7:0]         crc_q;
	logic [ENTRIES-1:0] valid_q;

	logic [ENTRY_W-1:0] entry_s1;
	logic [2:0]         bit_s1;
	logic [7:0]         value_s1;
	logic [2:0]         lane_s1;

	logic [3:0]         pix_x;
	logic [3:0]         pix_y;
	logic [ENTRY_W-1:0] pix_entry;
	logic [POS_W-1:0]   pos_offset;
	logic [7:0]         plane_k;
	logic               pos_in_frame;
	logic               idle_ready;
	logic               in_acc;
	logic               out_pop;
	out_word_t          header_word;

	logic [PLANE_W-1:0] plane_rd_data;
	logic [PLANE_W-1:0] old_word;
	logic [PLANE_W-1:0] pix_mask;
	logic [PLANE_W-1:0] cleared_word;
	logic [7:0]         pix_value;
	logic [7:0]         rd_byte;
	logic [7:0]         gamma_rd_data;

	logic               plane_rd_en;
	logic [ENTRY_W-1:0] plane_rd_addr;
	logic               plane_wr_en;
	logic [PLANE_W-1:0] plane_wr_data;
	logic               gamma_wr_en;
	logic               gamma_rd_en;
	logic               push;
	out_word_t          push_word;

	logic [OFIFO_CNT_W-1:0] fifo_count;

	always_comb begin
		unique case (rotation_q)
			ROT_NONE: begin
				pix_x = in_word.col;
				pix_y = in_word.row;
			end
			ROT_QUARTER: begin
				pix_x = in_word.row;
				pix_y = COORD_MAX - in_word.col;
			end
			ROT_HALF: begin
				pix_x = COORD_MAX - in_word.col;
				pix_y = COORD_MAX - in_word.row;
			end
			ROT_THREE_QUARTER: begin
				pix_x = COORD_MAX - in_word.row;
				pix_y = in_word.col;
			end
		endcase
	end

	assign pix_entry    = {pix_x[3], pix_y};
	assign pos_offset   = pos_q - POS_FIRST_PLANE;
	assign plane_k      = 8'(pos_offset);
	assign pos_in_frame = (pos_q >= POS_FIRST_PLANE) && (pos_q < POS_CRC);

	assign idle_ready = (state_q == ST_IDLE) && (fifo_count <= OFIFO_ACCEPT_MAX);
	assign in_stall   = !idle_ready;
	assign in_acc     = in_valid && idle_ready;
	assign out_pop    = out_valid && !out_stall;

	always_comb begin
		header_word.last = 1'b0;
		priority if (pos_q == POS_MAGIC_FIRST) begin
			header_word.out_byte = magic_first_q;
		end else if (pos_q == POS_MAGIC_SECOND) begin
			header_word.out_byte = magic_second_q;
		end else if (pos_q == POS_COMMAND) begin
			header_word.out_byte = frame_command_q;
		end else begin
			header_word.out_byte = crc_q;
			header_word.last     = 1'b1;
		end
	end

	assign old_word  = valid_q[entry_s1] ? plane_rd_data : '0;
	assign pix_value = gamma_enable_q ? gamma_rd_data : value_s1;

	always_comb begin
		pix_mask     = '0;
		rd_byte      = 8'd0;
		cleared_word = old_word;
		for (int p = 0; p < PLANES; p++) begin
			pix_mask[8*p +: 8] = pix_value[p] ? (8'd1 << bit_s1) : 8'd0;
			if (lane_s1 == 3'(p)) begin
				rd_byte               = old_word[8*p +: 8];
				cleared_word[8*p +: 8] = 8'd0;
			end
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					unique case (in_word.operation)
						OP_PIXEL: state_next = ST_PIXEL;
						OP_GAMMA: state_next = ST_IDLE;
						OP_READ:  state_next = pos_in_frame ? ST_READ : ST_IDLE;
						OP_SHOW:  state_next = ST_SHOW1;
					endcase
				end
			end
			ST_PIXEL: state_next = ST_IDLE;
			ST_READ:  state_next = ST_IDLE;
			ST_SHOW1: state_next = ST_SHOW2;
			ST_SHOW2: state_next = ST_IDLE;
			default:  state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		plane_rd_en   = 1'b0;
		plane_rd_addr = pix_entry;
		plane_wr_en   = 1'b0;
		plane_wr_data = old_word | pix_mask;
		gamma_wr_en   = 1'b0;
		gamma_rd_en   = 1'b0;
		push          = 1'b0;
		push_word     = '{out_byte: magic_first_q, last: 1'b0};
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					unique case (in_word.operation)
						OP_PIXEL: begin
							plane_rd_en = 1'b1;
							gamma_rd_en = 1'b1;
						end
						OP_GAMMA: begin
							gamma_wr_en = 1'b1;
						end
						OP_READ: begin
							if (pos_in_frame) begin
								plane_rd_en   = 1'b1;
								plane_rd_addr = plane_k[4:0];
							end else begin
								push      = 1'b1;
								push_word = header_word;
							end
						end
						OP_SHOW: begin
							push = 1'b1;
						end
					endcase
				end
			end
			ST_PIXEL: begin
				plane_wr_en = 1'b1;
			end
			ST_READ: begin
				plane_wr_en   = 1'b1;
				plane_wr_data = cleared_word;
				push          = 1'b1;
				push_word     = '{out_byte: rd_byte, last: 1'b0};
			end
			ST_SHOW1: begin
				push      = 1'b1;
				push_word = '{out_byte: magic_second_q, last: 1'b0};
			end
			ST_SHOW2: begin
				push      = 1'b1;
				push_word = '{out_byte: show_command_q, last: 1'b1};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotation_q      <= ROT_NONE;
			gamma_enable_q  <= 1'b0;
			magic_first_q   <= 8'd0;
			magic_second_q  <= 8'd0;
			frame_command_q <= 8'd0;
			show_command_q  <= 8'd0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_ROTATION:      rotation_q      <= cfg_data[1:0];
				REG_GAMMA_ENABLE:  gamma_enable_q  <= cfg_data[0];
				REG_MAGIC_FIRST:   magic_first_q   <= cfg_data;
				REG_MAGIC_SECOND:  magic_second_q  <= cfg_data;
				REG_FRAME_COMMAND: frame_command_q <= cfg_data;
				REG_SHOW_COMMAND:  show_command_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q   <= '0;
			crc_q   <= 8'd0;
			valid_q <= '0;
		end else begin
			state_q <= state_next;
			if (in_acc && (in_word.operation == OP_READ)) begin
				if (pos_q == POS_CRC) begin
					pos_q <= '0;
					crc_q <= 8'd0;
				end else begin
					pos_q <= pos_q + 1'b1;
				end
			end
			if (state_q == ST_READ) begin
				crc_q <= crc8_update(crc_q, rd_byte);
			end
			if (plane_wr_en) begin
				valid_q[entry_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			entry_s1 <= plane_rd_addr;
			bit_s1   <= pix_x[2:0];
			value_s1 <= in_word.value;
			lane_s1  <= plane_k[7:5];
		end
	end

	pbpb_ram #(
		.WIDTH(PLANE_W),
		.DEPTH(ENTRIES)
	) u_plane_ram (
		.clk     (clk),
		.wr_en   (plane_wr_en),
		.wr_addr (entry_s1),
		.wr_data (plane_wr_data),
		.rd_en   (plane_rd_en),
		.rd_addr (plane_rd_addr),
		.rd_data (plane_rd_data)
	);

	pbpb_ram #(
		.WIDTH(8),
		.DEPTH(GAMMA_DEPTH)
	) u_gamma_ram (
		.clk     (clk),
		.wr_en   (gamma_wr_en),
		.wr_addr (in_word.gamma_index),
		.wr_data (in_word.value),
		.rd_en   (gamma_rd_en),
		.rd_addr (in_word.value),
		.rd_data (gamma_rd_data)
	);

	pbpb_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.pop       (out_pop),
		.out_valid (out_valid),
		.out_word  (out_word),
		.count     (fifo_count)
	);

endmodule

`default_nettype wire

FILE: src/pbpb_ram.sv
// ----------------------------------------------------------------------------
// pbpb_ram
// Generic synchronous RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pbpb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]  wr_data,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output      logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

FILE: src/pbpb_fifo.sv
// ----------------------------------------------------------------------------
// pbpb_fifo
// Small output queue that parts the packet builder from the output link.
// ----------------------------------------------------------------------------
`default_nettype none

module pbpb_fifo import pbpb_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   push,
	input  wire out_word_t              push_word,
	input  wire logic                   pop,
	output      logic                   out_valid,
	output      out_word_t              out_word,
	output      logic [OFIFO_CNT_W-1:0] count
);

	out_word_t              slot_q [OFIFO_DEPTH];
	logic [OFIFO_PTR_W-1:0] wr_ptr_q;
	logic [OFIFO_PTR_W-1:0] rd_ptr_q;
	logic [OFIFO_CNT_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_word;
		end
	end

	assign out_valid = (count_q != '0);
	assign out_word  = slot_q[rd_ptr_q];
	assign count     = count_q;

endmodule

`default_nettype wire

FILE: src/pbpb_checker.sv
// ----------------------------------------------------------------------------
// pbpb_port_checker
// Port-level checks of the packet builder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "panel_bitplane_packet_builder_core_assert.svh"

module pbpb_port_checker import pbpb_pkg::*; (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      in_valid,
	input wire logic      in_stall,
	input wire in_word_t  in_word,
	input wire logic      out_valid,
	input wire logic      out_stall,
	input wire out_word_t out_word
);

	logic in_acc;
	logic show_acc;
	logic pixel_acc;
	logic gamma_acc;
	logic out_held;

	assign in_acc    = in_valid && !in_stall;
	assign show_acc  = in_acc && (in_word.operation == OP_SHOW);
	assign pixel_acc = in_acc && (in_word.operation == OP_PIXEL);
	assign gamma_acc = in_acc && (in_word.operation == OP_GAMMA);
	assign out_held  = out_valid && out_stall;

	// A waiting word must not be lost or altered while the link stalls.
	`PBPB_ASSERT_NEXT(a_out_hold, clk, arst_n, out_held, out_valid && $stable(out_word))

	// A show item occupies the block while its three trailer words are queued.
	`PBPB_ASSERT_NEXT2(a_show_busy, clk, arst_n, show_acc, in_stall, in_stall)

	// A pixel holds the block for the write-back of the merged entry.
	`PBPB_ASSERT_NEXT(a_pixel_busy, clk, arst_n, pixel_acc, in_stall)

	// A gamma load finishes at once and queues nothing.
	`PBPB_ASSERT_NEXT(a_gamma_free, clk, arst_n, gamma_acc, !in_stall)

endmodule

bind panel_bitplane_packet_builder_core pbpb_port_checker u_pbpb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.in_word   (in_word),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_word  (out_word)
);

`default_nettype wire

FILE: bench/pbpb_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bit-plane packet builder checker
// Watches the configuration port and both word channels. It keeps its own
// copy of the plane store, gamma table and packet progress, predicts every
// output word and compares each accepted one with the oldest prediction.
// ----------------------------------------------------------------------------

module pbpb_checker import pbpb_pkg::*; #(
	parameter int PLANES    = 8,
	parameter int FRAME_LEN = 256
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_stall,
	input  in_word_t               in_word,
	input  logic                   out_valid,
	input  logic                   out_stall,
	input  out_word_t              out_word,
	input  logic                   cfg_write,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output int unsigned            mismatches,
	output int unsigned            outstanding,
	output int unsigned            words_checked,
	output int unsigned            packets_seen
);

	logic [63:0] plane_bits [ENTRIES];
	logic [7:0]  gamma_lut [GAMMA_DEPTH];
	logic [8:0]  pkt_pos;
	logic [7:0]  pkt_crc;
	logic [1:0]  rotation;
	logic        gamma_on;
	logic [7:0]  magic_a;
	logic [7:0]  magic_b;
	logic [7:0]  frame_cmd;
	logic [7:0]  show_cmd;
	out_word_t   expected_words [$];
	out_word_t   want_word;
	int unsigned fail_count = 0;
	int unsigned checked_count = 0;
	int unsigned packet_count = 0;
	int unsigned waiting = 0;

	assign mismatches    = fail_count;
	assign outstanding   = waiting;
	assign words_checked = checked_count;
	assign packets_seen  = packet_count;

	function automatic logic [7:0] crc8_next(logic [7:0] acc, logic [7:0] data);
		logic [7:0] r;
		r = acc;
		for (int i = 7; i >= 0; i--) begin
			if (r[7] ^ data[i]) begin
				r = {r[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				r = {r[6:0], 1'b0};
			end
		end
		return r;
	endfunction

	task automatic report(string what, logic [7:0] got, logic [7:0] want);
		fail_count++;
		if (fail_count <= 30) begin
			$display("%0t ns: %s: got %02h, expected %02h", $time, what, got, want);
		end
	endtask

	task automatic place_pixel(in_word_t w);
		logic [3:0] x;
		logic [3:0] y;
		logic [7:0] level;
		logic [4:0] entry;
		case (rotation)
			ROT_QUARTER: begin
				x = w.row;
				y = COORD_MAX - w.col;
			end
			ROT_HALF: begin
				x = COORD_MAX - w.col;
				y = COORD_MAX - w.row;
			end
			ROT_THREE_QUARTER: begin
				x = COORD_MAX - w.row;
				y = w.col;
			end
			default: begin
				x = w.col;
				y = w.row;
			end
		endcase
		level = gamma_on ? gamma_lut[w.value] : w.value;
		entry = {x[3], y};
		for (int p = 0; p < PLANES && p < 8; p++) begin
			if (level[p]) begin
				plane_bits[entry][8 * p + int'(x[2:0])] = 1'b1;
			end
		end
	endtask

	function automatic out_word_t next_packet_byte();
		out_word_t r;
		int unsigned k;
		int unsigned plane;
		logic [4:0] entry;
		r.out_byte = 8'h00;
		r.last = 1'b0;
		if (pkt_pos == 9'd0) begin
			r.out_byte = magic_a;
		end else if (pkt_pos == 9'd1) begin
			r.out_byte = magic_b;
		end else if (pkt_pos == 9'd2) begin
			r.out_byte = frame_cmd;
		end else if (int'(pkt_pos) < 3 + FRAME_LEN) begin
			k = int'(pkt_pos) - 3;
			plane = k / 32;
			entry = 5'(k % 32);
			if (plane < PLANES) begin
				r.out_byte = plane_bits[entry][8 * plane +: 8];
				plane_bits[entry][8 * plane +: 8] = 8'h00;
			end
			pkt_crc = crc8_next(pkt_crc, r.out_byte);
		end else begin
			r.out_byte = pkt_crc;
			r.last = 1'b1;
			pkt_crc = 8'h00;
			pkt_pos = 9'd0;
			packet_count++;
			return r;
		end
		pkt_pos = pkt_pos + 9'd1;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				plane_bits[i] = '0;
			end
			for (int i = 0; i < GAMMA_DEPTH; i++) begin
				gamma_lut[i] = '0;
			end
			pkt_pos = '0;
			pkt_crc = '0;
			rotation = ROT_NONE;
			gamma_on = 1'b0;
			magic_a = '0;
			magic_b = '0;
			frame_cmd = '0;
			show_cmd = '0;
			expected_words.delete();
			waiting = 0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_ROTATION:      rotation = cfg_data[1:0];
					REG_GAMMA_ENABLE:  gamma_on = cfg_data[0];
					REG_MAGIC_FIRST:   magic_a = cfg_data;
					REG_MAGIC_SECOND:  magic_b = cfg_data;
					REG_FRAME_COMMAND: frame_cmd = cfg_data;
					REG_SHOW_COMMAND:  show_cmd = cfg_data;
					default: begin
					end
				endcase
			end
			// Predictions go in first so that a word leaving on the same edge still finds one.
			if (in_valid && !in_stall) begin
				case (in_word.operation)
					OP_PIXEL: place_pixel(in_word);
					OP_GAMMA: gamma_lut[in_word.gamma_index] = in_word.value;
					OP_READ:  expected_words.push_back(next_packet_byte());
					OP_SHOW: begin
						expected_words.push_back(out_word_t'{magic_a, 1'b0});
						expected_words.push_back(out_word_t'{magic_b, 1'b0});
						expected_words.push_back(out_word_t'{show_cmd, 1'b1});
					end
					default: begin
					end
				endcase
			end
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					report("output word with nothing expected", out_word.out_byte, 8'h00);
				end else begin
					want_word = expected_words.pop_front();
					checked_count++;
					if (out_word.out_byte !== want_word.out_byte) begin
						report("packet byte", out_word.out_byte, want_word.out_byte);
					end
					if (out_word.last !== want_word.last) begin
						report("last flag", 8'(out_word.last), 8'(want_word.last));
					end
				end
			end
			waiting = expected_words.size();
		end
	end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bit-plane packet builder testbench
// Drives pixels, gamma loads, packet reads and show requests into the block
// under four register settings, with random gaps and output stalls, and
// leaves the prediction and comparison of every output word to the checker.
// ----------------------------------------------------------------------------

module testbench;
	import pbpb_pkg::*;

	localparam int PLANES        = 8;
	localparam int FRAME_LEN     = 256;
	localparam int PACKET_LEN    = FRAME_LEN + 4;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int SETTLE_CYCLES = 8;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	in_word_t               in_word = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	out_word_t              out_word;
	logic                   cfg_write = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = REG_ROTATION;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	int unsigned mismatches;
	int unsigned outstanding;
	int unsigned words_checked;
	int unsigned packets_seen;
	int unsigned cycles = 0;
	int unsigned items_sent = 0;
	int unsigned read_count = 0;
	int unsigned packets_read = 0;
	int unsigned stall_left = 0;
	logic        quiet = 1'b0;
	logic        gamma_on = 1'b0;
	logic [7:0]  gamma_written [$];

	panel_bitplane_packet_builder_core #(
		.PLANES(PLANES),
		.FRAME_LEN(FRAME_LEN)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_word(in_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word(out_word),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	pbpb_checker #(
		.PLANES(PLANES),
		.FRAME_LEN(FRAME_LEN)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_word(in_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word(out_word),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatches(mismatches),
		.outstanding(outstanding),
		.words_checked(words_checked),
		.packets_seen(packets_seen)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (quiet) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 99) < 75) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= 1'b1;
			stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
		end
	end

	function automatic in_word_t word_of(op_t op, logic [3:0] c, logic [3:0] r, logic [7:0] v,
		logic [7:0] gi);
		in_word_t w;
		w.operation = op;
		w.col = c;
		w.row = r;
		w.value = v;
		w.gamma_index = gi;
		return w;
	endfunction

	function automatic int unsigned gap_len();
		int unsigned roll;
		if (quiet) begin
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 60) begin
			return 0;
		end else if (roll < 93) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(6, 30);
	endfunction

	// With the gamma table applied, only entries already loaded may be looked up.
	function automatic logic [7:0] brightness();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (gamma_on) begin
			return gamma_written[$urandom_range(0, gamma_written.size() - 1)];
		end
		if (roll < 10) begin
			return 8'h00;
		end else if (roll < 20) begin
			return 8'hFF;
		end
		return 8'($urandom);
	endfunction

	task automatic send(in_word_t w);
		int unsigned gap;
		gap = gap_len();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		items_sent++;
		if (w.operation == OP_GAMMA) begin
			gamma_written.push_back(w.gamma_index);
		end
		if (w.operation == OP_READ) begin
			read_count++;
			if (read_count == PACKET_LEN) begin
				read_count = 0;
				packets_read++;
			end
		end
	endtask

	task automatic send_item(op_t op);
		logic [7:0] v;
		v = (op == OP_PIXEL) ? brightness() : 8'($urandom);
		send(word_of(op, 4'($urandom), 4'($urandom), v, 8'($urandom)));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do begin
			@(negedge clk);
		end while (outstanding != 0);
		@(posedge clk);
	endtask

	task automatic set_registers(logic [1:0] rot, logic gen, logic [7:0] mf, logic [7:0] ms,
		logic [7:0] fc, logic [7:0] sc);
		logic [CFG_INDEX_W-1:0] idx [6];
		logic [CFG_DATA_W-1:0]  val [6];
		idx = '{REG_ROTATION, REG_GAMMA_ENABLE, REG_MAGIC_FIRST, REG_MAGIC_SECOND,
			REG_FRAME_COMMAND, REG_SHOW_COMMAND};
		val = '{8'(rot), 8'(gen), mf, ms, fc, sc};
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		for (int i = 0; i < 6; i++) begin
			cfg_write <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			@(posedge clk);
		end
		cfg_write <= 1'b0;
		gamma_on = gen;
	endtask

	// A frame is a burst of pixels followed by a share of the packet reads, or by reads up to
	// the end of the current packet, with a little noise mixed into both.
	task automatic run_frame(int unsigned pixel_count, int unsigned read_quota, logic to_end);
		int unsigned start_packets;
		int unsigned roll;
		int unsigned hold_at;
		int unsigned reads_done;
		hold_at = $urandom_range(10, 50);
		reads_done = 0;
		for (int unsigned i = 0; i < pixel_count; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < 80) begin
				send_item(OP_PIXEL);
			end else if (roll < 88) begin
				send_item(OP_GAMMA);
			end else if (roll < 94) begin
				send_item(OP_SHOW);
			end else begin
				send_item(OP_READ);
			end
		end
		drain();
		start_packets = packets_read;
		while (to_end ? (packets_read == start_packets) : (reads_done < read_quota)) begin
			roll = $urandom_range(0, 99);
			if (roll < 92) begin
				send_item(OP_READ);
				reads_done++;
				if (reads_done == hold_at) begin
					drain();
				end
			end else if (roll < 95) begin
				send_item(OP_PIXEL);
			end else if (roll < 98) begin
				send_item(OP_SHOW);
			end else begin
				send_item(OP_GAMMA);
			end
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_registers(ROT_NONE, 1'b0, 8'h00, 8'hFF, 8'h00, 8'hFF);

		send(word_of(OP_SHOW, 4'h0, 4'h0, 8'h00, 8'h00));
		send(word_of(OP_GAMMA, 4'hF, 4'hF, 8'h00, 8'h00));
		send(word_of(OP_GAMMA, 4'h0, 4'h0, 8'hFF, 8'hFF));
		send(word_of(OP_GAMMA, 4'h5, 4'hA, 8'hAA, 8'h55));
		send(word_of(OP_GAMMA, 4'hA, 4'h5, 8'h55, 8'hAA));
		send(word_of(OP_PIXEL, 4'h0, 4'h0, 8'hFF, 8'hFF));
		send(word_of(OP_PIXEL, 4'hF, 4'hF, 8'hFF, 8'h00));
		send(word_of(OP_PIXEL, 4'hF, 4'h0, 8'h01, 8'h00));
		send(word_of(OP_PIXEL, 4'h0, 4'hF, 8'h80, 8'h00));
		send(word_of(OP_PIXEL, 4'h7, 4'h8, 8'h00, 8'h00));
		send(word_of(OP_PIXEL, 4'h8, 4'h7, 8'h81, 8'h00));
		send(word_of(OP_PIXEL, 4'hF, 4'h0, 8'h0E, 8'h00));
		send(word_of(OP_READ, 4'hF, 4'hF, 8'hFF, 8'hFF));
		send(word_of(OP_READ, 4'h0, 4'h0, 8'h00, 8'h00));
		send(word_of(OP_READ, 4'hF, 4'h0, 8'hFF, 8'h00));
		send(word_of(OP_SHOW, 4'hF, 4'hF, 8'hFF, 8'hFF));
		send(word_of(OP_READ, 4'h0, 4'hF, 8'h00, 8'hFF));
		send(word_of(OP_READ, 4'h3, 4'hC, 8'h5A, 8'hA5));
		send(word_of(OP_SHOW, 4'h0, 4'h0, 8'h00, 8'h00));
		drain();

		run_frame(10, 60, 1'b0);
		set_registers(ROT_QUARTER, 1'b1, 8'hFF, 8'h00, 8'hFF, 8'h00);
		run_frame(10, 60, 1'b0);
		quiet = 1'b1;
		set_registers(ROT_HALF, 1'b0, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
		run_frame(10, 60, 1'b0);
		quiet = 1'b0;
		set_registers(ROT_THREE_QUARTER, 1'b1, 8'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom));
		run_frame(10, 0, 1'b1);

		drain();
		repeat (16) @(posedge clk);
		@(negedge clk);
		$display("Sent %0d input words; checked %0d output words and %0d complete packets.",
			items_sent, words_checked, packets_seen);
		$display("All four rotations were run, with the gamma table both bypassed and applied.");
		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
